// ===== rtl/vlac_pkg.sv =====
// Shared types, constants and register codes of the Vigenere cipher unit.
package vlac_pkg;

  // Number of key slots that the key_slot field can address.
  localparam int unsigned KEY_SLOTS     = 64;
  localparam int unsigned KEY_DEPTH_DEF = 64;

  // Alphabet constants.
  localparam logic [7:0] LETTERS    = 8'd26;
  localparam logic [7:0] ASCII_LO   = 8'd33;
  localparam logic [7:0] ASCII_HI   = 8'd126;
  localparam logic [7:0] ASCII_SPAN = ASCII_HI - ASCII_LO + 8'd1;

  // Configuration port.
  localparam int unsigned CFG_IW = 2;
  localparam int unsigned CFG_DW = 7;
  localparam logic [CFG_IW-1:0] CFG_DECRYPT = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_LETTER  = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_KEYLEN  = 2'd2;

  // Input word kinds.
  localparam logic MODE_KEY  = 1'b0;
  localparam logic MODE_TEXT = 1'b1;

  typedef logic [7:0] char_t;
  typedef logic [6:0] key_len_t;

  // Operating mode handed to the transform.
  typedef struct packed {
    logic decrypt;
    logic letter;
  } vlac_mode_t;

endpackage

// ===== rtl/vlac_if.sv =====
// Handshake channels of the Vigenere cipher unit: input, output and configuration.
interface vlac_in_if import vlac_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  mode;
  logic  [5:0] key_slot;
  char_t char_in;
  logic  word_end;

  modport source (output valid, mode, key_slot, char_in, word_end, input ready);
  modport sink   (input valid, mode, key_slot, char_in, word_end, output ready);
endinterface

interface vlac_out_if import vlac_pkg::*; ();
  logic  valid;
  logic  ready;
  char_t char_out;
  logic  word_end_out;

  modport source (output valid, char_out, word_end_out, input ready);
  modport sink   (input valid, char_out, word_end_out, output ready);
endinterface

interface vlac_cfg_if import vlac_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CFG_IW-1:0] idx;
  logic [CFG_DW-1:0] data;

  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

// ===== rtl/vigenere_letter_ascii_cipher_unit.sv =====
// Top level of the Vigenere cipher unit: key store, key position and output stage.
//
// Usage. Words arrive on in_i. A word with mode 0 writes char_in into key
// slot key_slot and gives no result; a slot at or beyond the store depth is
// dropped. A word with mode 1 is a text byte: it is combined with the key byte
// at the current key position and one word leaves on out_o, carrying the
// cipher byte and a copy of the word end mark. The key position advances per
// text byte, wraps at the key length and restarts at zero after a word end.
// Configuration registers (decrypt select, letter mode, key length) are
// written on cfg_i, which is always ready; write them only while idle.
// The result reaches out_o through the read stage, where the key store is
// read at acceptance, and then the output register, once that is free.
// Throughput is one word per cycle while out_o takes its words; the key
// position updates at each accepted text byte, and a key write followed
// directly by a text read of that slot sees the new byte written before it.
// When out_o stalls, one byte waits in the read stage and one in the output
// register; in_i drops ready only when both are full and out_o is not taken.
// Reset clears the pipeline, zeroes the key position and restores the
// register defaults; the key store is not cleared and must be written first.
module vigenere_letter_ascii_cipher_unit import vlac_pkg::*; #(
  parameter int unsigned KEY_DEPTH = KEY_DEPTH_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  vlac_in_if.sink    in_i,
  vlac_out_if.source out_o,
  vlac_cfg_if.sink   cfg_i
);

  // Only the first 64 slots are addressable, so the store never exceeds them.
  localparam int unsigned KEY_LIM = (KEY_DEPTH < KEY_SLOTS) ? KEY_DEPTH : KEY_SLOTS;
  localparam int unsigned KEY_AW  = (KEY_LIM > 1) ? $clog2(KEY_LIM) : 1;
  localparam key_len_t    KEY_LIM_L = key_len_t'(KEY_LIM);

  // Configuration registers.
  logic     decrypt_q, decrypt_d;
  logic     letter_q, letter_d;
  key_len_t key_len_q, key_len_d;

  // Key position and pipeline state.
  logic [KEY_AW-1:0] key_pos_q, key_pos_d;
  logic              s1_valid_q, s1_valid_d;
  logic              s1_wend_q;
  char_t             s1_char_q;
  logic              out_valid_q, out_valid_d;
  char_t             out_char_q;
  logic              out_wend_q;

  logic              in_fire, txt_fire, key_we;
  logic              out_free, s1_adv;
  key_len_t          eff_len, pos_ext, pos_inc;
  logic [KEY_AW-1:0] pos;
  char_t             key_byte, res_char;
  vlac_mode_t        mode;

  // Configuration writes are always accepted; unknown indexes are ignored.
  assign cfg_i.ready = 1'b1;

  always_comb begin
    decrypt_d = decrypt_q;
    letter_d  = letter_q;
    key_len_d = key_len_q;
    if (cfg_i.valid) begin
      case (cfg_i.idx)
        CFG_DECRYPT: decrypt_d = cfg_i.data[0];
        CFG_LETTER:  letter_d  = cfg_i.data[0];
        CFG_KEYLEN:  key_len_d = key_len_t'(cfg_i.data);
        default: ;
      endcase
    end
  end

  // Handshake. The read stage moves on when the output register is free.
  assign out_free    = !out_valid_q || out_o.ready;
  assign s1_adv      = s1_valid_q && out_free;
  assign in_i.ready  = !s1_valid_q || out_free;
  assign in_fire     = in_i.valid && in_i.ready;
  assign txt_fire    = in_fire && (in_i.mode == MODE_TEXT);
  assign key_we      = in_fire && (in_i.mode == MODE_KEY) &&
                       ({1'b0, in_i.key_slot} < KEY_LIM_L);

  // Effective key length is clamped to one through the store depth. A
  // position left over from a longer key falls back to slot zero.
  always_comb begin
    if (key_len_q == '0) begin
      eff_len = key_len_t'(1);
    end else if (key_len_q > KEY_LIM_L) begin
      eff_len = KEY_LIM_L;
    end else begin
      eff_len = key_len_q;
    end
    pos_ext = key_len_t'(key_pos_q);
    pos     = (pos_ext < eff_len) ? key_pos_q : '0;
    pos_inc = key_len_t'(pos) + key_len_t'(1);
    key_pos_d = key_pos_q;
    if (txt_fire) begin
      if (in_i.word_end || pos_inc >= eff_len) begin
        key_pos_d = '0;
      end else begin
        key_pos_d = pos_inc[KEY_AW-1:0];
      end
    end
  end

  vlac_ram #(
    .WIDTH (8),
    .DEPTH (KEY_LIM)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (in_i.key_slot[KEY_AW-1:0]),
    .wdata_i (in_i.char_in),
    .re_i    (txt_fire),
    .raddr_i (pos),
    .rdata_o (key_byte)
  );

  // The key byte comes from the registered read port; the text byte waits beside it.
  assign mode.decrypt = decrypt_q;
  assign mode.letter  = letter_q;

  vlac_xform u_xform (
    .mode_i (mode),
    .text_i (s1_char_q),
    .key_i  (key_byte),
    .char_o (res_char)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (txt_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decrypt_q   <= 1'b0;
      letter_q    <= 1'b1;
      key_len_q   <= key_len_t'(1);
      key_pos_q   <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      decrypt_q   <= decrypt_d;
      letter_q    <= letter_d;
      key_len_q   <= key_len_d;
      key_pos_q   <= key_pos_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (txt_fire) begin
      s1_char_q <= in_i.char_in;
      s1_wend_q <= in_i.word_end;
    end
    if (s1_adv) begin
      out_char_q <= res_char;
      out_wend_q <= s1_wend_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.char_out     = out_char_q;
  assign out_o.word_end_out = out_wend_q;

  // A text byte waiting in the read stage keeps its byte until it moves on.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_char_q))
    else $error("read stage lost or changed a waiting byte");

  // After a text byte the key position lies below the key length in force.
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    txt_fire |=> key_len_t'(key_pos_q) < $past(eff_len))
    else $error("key position beyond key length");

  // A word end restarts the key at slot zero.
  a_word_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    txt_fire && in_i.word_end |=> key_pos_q == '0)
    else $error("key position not restarted after word end");

  // A key write never produces a result word.
  a_key_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_i.mode == MODE_KEY) && !s1_valid_q |=> !s1_valid_q)
    else $error("key write entered the result path");

endmodule

// ===== rtl/vlac_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module vlac_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 64,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/vlac_xform.sv =====
// Letter and printable-ASCII combination of one text byte with one key byte.
module vlac_xform import vlac_pkg::*; (
  input  vlac_mode_t mode_i,
  input  char_t      text_i,
  input  char_t      key_i,
  output char_t      char_o
);

  // Upper-cased alphabet index; anything that is not a letter counts as A.
  function automatic logic [4:0] letter_idx(input char_t c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h61 && c <= 8'h7a) begin
      r = 5'(c - 8'h61);
    end else if (c >= 8'h41 && c <= 8'h5a) begin
      r = 5'(c - 8'h41);
    end
    return r;
  endfunction

  // (c - 33) mod 94 for any byte, as c + 61 reduced by compare and subtract.
  function automatic logic [6:0] ascii_off(input char_t c);
    logic [8:0] v;
    logic [8:0] span;
    logic [6:0] r;
    span = {1'b0, ASCII_SPAN};
    v = {1'b0, c} + {1'b0, ASCII_SPAN - ASCII_LO};
    if (v >= 9'(3 * span)) begin
      r = 7'(v - 9'(3 * span));
    end else if (v >= 9'(2 * span)) begin
      r = 7'(v - 9'(2 * span));
    end else if (v >= span) begin
      r = 7'(v - span);
    end else begin
      r = 7'(v);
    end
    return r;
  endfunction

  logic [4:0] ti, ki;
  logic [5:0] lsum;
  logic [4:0] lres;
  logic [6:0] to, ko;
  logic [7:0] asum;
  logic [6:0] ares;

  always_comb begin
    ti = letter_idx(text_i);
    ki = letter_idx(key_i);
    if (mode_i.decrypt) begin
      lsum = {1'b0, ti} + 6'(LETTERS) - {1'b0, ki};
    end else begin
      lsum = {1'b0, ti} + {1'b0, ki};
    end
    lres = (lsum >= 6'(LETTERS)) ? 5'(lsum - 6'(LETTERS)) : lsum[4:0];

    to = ascii_off(text_i);
    ko = ascii_off(key_i);
    if (mode_i.decrypt) begin
      asum = (to >= ko) ? {1'b0, to} - {1'b0, ko} : {1'b0, to} + ASCII_SPAN - {1'b0, ko};
    end else begin
      asum = {1'b0, to} + {1'b0, ko};
    end
    ares = (asum >= ASCII_SPAN) ? 7'(asum - ASCII_SPAN) : asum[6:0];

    if (mode_i.letter) begin
      char_o = 8'h41 + {3'b000, lres};
    end else begin
      char_o = ASCII_LO + {1'b0, ares};
    end
  end

endmodule
